// ===== rtl/frr_pkg.sv =====
// Shared types and constants for the reflect-border FIR row filter.
// No dependencies; used by frr_mac and fir_row_filter_reflect_border.
`timescale 1ns / 1ps

package frr_pkg;

  localparam int TAPS_DEF      = 5;
  localparam int MAX_WIDTH_DEF = 4096;
  localparam int NTAPREG       = 5;

  localparam int SAMPLE_W  = 16;
  localparam int TAP_W     = 16;
  localparam int WIDTH_W   = 13;
  localparam int OUT_W     = 20;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int PROD_W    = TAP_W + SAMPLE_W + 1;

  localparam int FRAC_SHIFT = 14;
  localparam int SAT_HI     = 524287;
  localparam int SAT_LO     = -524288;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TAP_0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 3'd5;

  localparam logic [TAP_W-1:0]   TAP_CENTER_RST = 16'd16384;
  localparam logic [WIDTH_W-1:0] ROW_WIDTH_RST  = 13'd640;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [TAP_W-1:0]    tap_t;
  typedef logic [WIDTH_W-1:0]  col_t;

  // Control for one result issued from the job register into the MAC.
  typedef struct packed {
    logic valid;
    logic row_end;
  } issue_t;

endpackage

// ===== rtl/frr_mac.sv =====
// Tap selection with mirrored borders, product stage and sum/saturate stage.
// Depends on frr_pkg; instantiated by fir_row_filter_reflect_border.
`timescale 1ns / 1ps

module frr_mac #(
  parameter int TAPS = frr_pkg::TAPS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic [frr_pkg::NTAPREG-1:0][frr_pkg::TAP_W-1:0] taps,
  input  logic [2*(TAPS/2):0][frr_pkg::SAMPLE_W-1:0]      win,
  input  frr_pkg::col_t                           pos,
  input  frr_pkg::col_t                           cpos,
  input  frr_pkg::col_t                           lastidx,
  input  frr_pkg::issue_t                         issue,
  output logic                                    ready,
  output logic signed [frr_pkg::OUT_W-1:0]        filtered,
  output logic                                    row_end,
  output logic                                    result_valid,
  input  logic                                    result_stall
);
  import frr_pkg::*;

  localparam int HALF = TAPS / 2;
  localparam int WIN  = 2 * HALF + 1;
  localparam int IDXW = (WIN > 1) ? $clog2(WIN) : 1;
  localparam int IW   = WIDTH_W + 3;
  localparam int SW   = PROD_W + $clog2(TAPS + 1);

  function automatic logic signed [IW-1:0] mirror(input logic signed [IW-1:0] q,
                                                  input logic signed [IW-1:0] last);
    logic signed [IW-1:0] r;
    if (q > last) begin
      r = (last <<< 1) - q;
    end else if (q < 0) begin
      r = -q;
    end else begin
      r = q;
    end
    if (r < 0) begin
      r = '0;
    end
    if (r > last) begin
      r = last;
    end
    return r;
  endfunction

  logic signed [IW-1:0] pos_s, cpos_s, last_s;
  logic signed [PROD_W-1:0] prod_next [TAPS];
  logic signed [PROD_W-1:0] prod [TAPS];
  logic prod_valid;
  logic prod_row_end;
  logic out_ready;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] shifted;
  logic signed [OUT_W-1:0] sat;

  assign pos_s  = $signed({3'b000, pos});
  assign cpos_s = $signed({3'b000, cpos});
  assign last_s = $signed({3'b000, lastidx});

  for (genvar i = 0; i < TAPS; i++) begin : g_tap
    logic signed [IW-1:0] qv;
    logic signed [IW-1:0] off;
    sample_t smp;
    tap_t tapv;

    assign qv  = mirror(pos_s + IW'(i - HALF), last_s);
    // Window entry 0 holds the newest sample, which is row position cpos.
    assign off = cpos_s - qv;
    assign smp = (off >= 0 && off < IW'(WIN)) ? win[off[IDXW-1:0]] : '0;
    if (i < NTAPREG) begin : g_reg
      assign tapv = taps[i];
    end else begin : g_zero
      assign tapv = '0;
    end
    assign prod_next[i] = PROD_W'($signed(tapv)) * PROD_W'($signed({1'b0, smp}));
  end

  assign out_ready = !result_valid || !result_stall;
  assign ready     = !prod_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (ready) begin
      prod_valid <= issue.valid;
    end
    if (ready) begin
      prod_row_end <= issue.row_end;
      for (int i = 0; i < TAPS; i++) begin
        prod[i] <= prod_next[i];
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < TAPS; i++) begin
      sum = sum + SW'(prod[i]);
    end
    // Arithmetic shift rounds toward minus infinity.
    shifted = sum >>> FRAC_SHIFT;
    if (shifted > SW'(SAT_HI)) begin
      sat = OUT_W'(SAT_HI);
    end else if (shifted < SW'(SAT_LO)) begin
      sat = OUT_W'(SAT_LO);
    end else begin
      sat = shifted[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= prod_valid;
    end
    if (out_ready && prod_valid) begin
      filtered <= sat;
      row_end  <= prod_row_end;
    end
  end

endmodule

// ===== rtl/fir_row_filter_reflect_border.sv =====
// Path: a sample's result passes through the job register, the product register and the result register.
// Throughput: one sample per cycle while result_stall is low; the last sample of a row holds
// sample_stall high while the job register issues its flush results one a cycle.
// Reset: taps go to 0,0,16384,0,0, row_width to 640, the window and column count to zero,
// and all pipeline stages empty.
// Top level; depends on frr_pkg and frr_mac.
`timescale 1ns / 1ps

module fir_row_filter_reflect_border #(
  parameter int TAPS      = frr_pkg::TAPS_DEF,
  parameter int MAX_WIDTH = frr_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [frr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [frr_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  frr_pkg::sample_t                  sample,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  output logic signed [frr_pkg::OUT_W-1:0]  filtered,
  output logic                              row_end,
  output logic                              result_valid,
  input  logic                              result_stall
);
  import frr_pkg::*;

  localparam int HALF = TAPS / 2;
  localparam int WIN  = 2 * HALF + 1;

  logic [NTAPREG-1:0][TAP_W-1:0] taps;
  col_t row_width;
  logic [WIN-1:0][SAMPLE_W-1:0] window;
  logic [WIN-1:0][SAMPLE_W-1:0] window_next;
  col_t column_count;

  col_t eff_w, lastidx, c;
  logic accept;

  // Job register: one accepted sample's window and the span of results it releases.
  logic job_valid;
  logic [WIN-1:0][SAMPLE_W-1:0] job_win;
  col_t job_p, job_end, job_c, job_last;
  logic job_flush;
  logic job_done;
  logic mac_ready;
  logic issue_fire;
  issue_t issue;

  always_comb begin
    if (row_width == '0) begin
      eff_w = col_t'(1);
    end else if (int'(row_width) > MAX_WIDTH) begin
      eff_w = col_t'(MAX_WIDTH);
    end else begin
      eff_w = row_width;
    end
    lastidx = eff_w - col_t'(1);
    c = (column_count > lastidx) ? lastidx : column_count;
  end

  always_comb begin
    window_next[0] = sample;
    for (int k = 1; k < WIN; k++) begin
      window_next[k] = window[k-1];
    end
  end

  assign issue_fire   = job_valid && mac_ready;
  assign job_done     = issue_fire && (job_p == job_end);
  assign sample_stall = job_valid && !job_done;
  assign accept       = sample_valid && !sample_stall;

  assign issue.valid   = job_valid;
  assign issue.row_end = job_flush && (job_p == job_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      taps         <= '0;
      taps[2]      <= TAP_CENTER_RST;
      row_width    <= ROW_WIDTH_RST;
      window       <= '0;
      column_count <= '0;
      job_valid    <= 1'b0;
    end else begin
      if (issue_fire) begin
        if (job_p == job_end) begin
          job_valid <= 1'b0;
        end else begin
          job_p <= job_p + col_t'(1);
        end
      end
      if (accept) begin
        window   <= window_next;
        job_win  <= window_next;
        job_c    <= c;
        job_last <= lastidx;
        if (c < lastidx) begin
          column_count <= c + col_t'(1);
          if (c >= HALF) begin
            job_valid <= 1'b1;
            job_p     <= c - col_t'(HALF);
            job_end   <= c - col_t'(HALF);
            job_flush <= 1'b0;
          end
        end else begin
          // Last sample of the row releases every result still pending.
          column_count <= '0;
          job_valid    <= 1'b1;
          job_p        <= (c >= HALF) ? c - col_t'(HALF) : '0;
          job_end      <= c;
          job_flush    <= 1'b1;
        end
      end
      if (cfg_we) begin
        if (cfg_index < REG_ROW_WIDTH) begin
          taps[cfg_index - REG_TAP_0] <= cfg_data[TAP_W-1:0];
        end else if (cfg_index == REG_ROW_WIDTH) begin
          row_width    <= cfg_data[WIDTH_W-1:0];
          column_count <= '0;
        end
      end
    end
  end

  frr_mac #(
    .TAPS(TAPS)
  ) u_mac (
    .clk          (clk),
    .rst          (rst),
    .taps         (taps),
    .win          (job_win),
    .pos          (job_p),
    .cpos         (job_c),
    .lastidx      (job_last),
    .issue        (issue),
    .ready        (mac_ready),
    .filtered     (filtered),
    .row_end      (row_end),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

// ===== tb/sv/fir_row_filter_reflect_border_checker.sv =====
// Scoreboard for the reflect-border FIR row filter: watches the configuration port and both
// channels, predicts every filtered sample and compares it with what the block delivers.
// Depends on frr_pkg.
`timescale 1ns / 1ps

module fir_row_filter_reflect_border_checker
  import frr_pkg::*;
#(
  parameter int TAPS      = TAPS_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DAT_W-1:0]        cfg_data,
  input  sample_t                     sample,
  input  logic                        sample_valid,
  input  logic                        sample_stall,
  input  logic signed [OUT_W-1:0]     filtered,
  input  logic                        row_end,
  input  logic                        result_valid,
  input  logic                        result_stall,
  output int                          errors,
  output int                          outstanding
);

  localparam int HALF = TAPS / 2;
  localparam int WIN  = 2 * HALF + 1;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
    logic                    row_end;
  } pixel_out_t;

  pixel_out_t              due_pixels[$];
  logic signed [TAP_W-1:0] tap_coef[NTAPREG];
  sample_t                 line_win[WIN];
  col_t                    width_reg;
  int                      column;

  // Mirror about the row edge without repeating the edge sample, then clamp into the row.
  function automatic int reflect(input int q, input int last);
    int r;
    r = q;
    if (r > last) r = 2 * last - r;
    else if (r < 0) r = -r;
    if (r < 0) r = 0;
    if (r > last) r = last;
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] filter_column(input int p, input int c,
                                                            input int w);
    longint acc;
    longint r;
    longint coef;
    int     q;
    int     off;
    acc = 0;
    for (int i = 0; i < TAPS; i++) begin
      q    = reflect(p - HALF + i, w - 1);
      off  = c - q;
      coef = (i < NTAPREG) ? longint'(tap_coef[i]) : 0;
      if (off >= 0 && off < WIN) acc += coef * longint'(line_win[off]);
    end
    r = acc >>> FRAC_SHIFT;
    if (r > SAT_HI) r = SAT_HI;
    if (r < SAT_LO) r = SAT_LO;
    return r[OUT_W-1:0];
  endfunction

  task automatic take_pixel(input sample_t s);
    int w;
    int c;
    int first;
    for (int i = WIN - 1; i > 0; i--) line_win[i] = line_win[i-1];
    line_win[0] = s;
    w = (width_reg == 0) ? 1 : int'(width_reg);
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (column > w - 1) column = w - 1;
    c = column;
    if (c < w - 1) begin
      if (c >= HALF) due_pixels.push_back(pixel_out_t'{filter_column(c - HALF, c, w), 1'b0});
      column = c + 1;
    end else begin
      // The last sample of a row flushes every result still waiting on right neighbors.
      first = (c >= HALF) ? c - HALF : 0;
      for (int p = first; p <= c; p++)
        due_pixels.push_back(pixel_out_t'{filter_column(p, c, w), p == c});
      column = 0;
    end
  endtask

  always @(posedge clk) begin : monitor
    pixel_out_t exp_px;
    if (rst) begin
      for (int i = 0; i < NTAPREG; i++) tap_coef[i] = '0;
      tap_coef[NTAPREG/2] = TAP_CENTER_RST;
      for (int i = 0; i < WIN; i++) line_win[i] = '0;
      width_reg = ROW_WIDTH_RST;
      column    = 0;
      due_pixels.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (due_pixels.size() == 0) begin
          errors++;
          $display("%0t: transaction with nothing expected, actual filtered %0d row_end %0b",
                   $time, filtered, row_end);
        end else begin
          exp_px = due_pixels.pop_front();
          if (filtered !== exp_px.filtered) begin
            errors++;
            $display("%0t: filtered mismatch, expected %0d, actual %0d",
                     $time, exp_px.filtered, filtered);
          end
          if (row_end !== exp_px.row_end) begin
            errors++;
            $display("%0t: row_end mismatch, expected %0b, actual %0b",
                     $time, exp_px.row_end, row_end);
          end
        end
      end
      if (cfg_we) begin
        if (int'(cfg_index) < NTAPREG) begin
          tap_coef[cfg_index] = cfg_data;
        end else if (cfg_index == REG_ROW_WIDTH) begin
          width_reg = cfg_data[WIDTH_W-1:0];
          column    = 0;
        end
      end
      if (sample_valid && !sample_stall) take_pixel(sample);
    end
    outstanding <= due_pixels.size();
  end

endmodule

// ===== tb/sv/fir_row_filter_reflect_border_tb.sv =====
// Top of the reflect-border FIR row filter testbench: clock, reset, directed and random
// stimulus with random idling on both channels, and the verdict.
// Depends on frr_pkg, fir_row_filter_reflect_border and fir_row_filter_reflect_border_checker.
`timescale 1ns / 1ps

module fir_row_filter_reflect_border_tb;
  import frr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_ROW_WIDTH + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;
  localparam logic [CFG_DAT_W-1:0] TAP_MAX      = 16'h7FFF;
  localparam logic [CFG_DAT_W-1:0] TAP_MIN      = 16'h8000;
  localparam logic [CFG_DAT_W-1:0] WIDTH_OVER   = 16'h1FFF;
  localparam sample_t              PIX_MAX      = 16'hFFFF;
  localparam int                   RANDOM_PIXELS = 150;
  localparam int                   WIDE_PIXELS   = 24;
  localparam int                   SETTLE_CYCLES = 8;

  logic                       clk          = 1'b0;
  logic                       rst          = 1'b1;
  logic                       cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index    = '0;
  logic [CFG_DAT_W-1:0]       cfg_data     = '0;
  sample_t                    sample       = '0;
  logic                       sample_valid = 1'b0;
  logic                       result_stall = 1'b0;
  logic                       sample_stall;
  logic signed [OUT_W-1:0]    filtered;
  logic                       row_end;
  logic                       result_valid;
  int                         errors;
  int                         outstanding;
  int                         send_gap_pct = 18;
  int                         recv_gap_pct = 75;

  fir_row_filter_reflect_border dut (.*);

  fir_row_filter_reflect_border_checker checker_i (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_stall <= rst ? 1'b0 : ($urandom_range(0, 99) < recv_gap_pct);
  end

  task automatic send_pixel(input sample_t v);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample       <= v;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every predicted result has come out, then let any sample that causes no
  // result drain through the pipeline.
  task automatic settle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic sample_t rand_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PIX_MAX;
      default: return sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CFG_DAT_W-1:0] rand_tap();
    case ($urandom_range(0, 7))
      0:       return TAP_MAX;
      1:       return TAP_MIN;
      2:       return '0;
      3:       return TAP_CENTER_RST;
      default: return CFG_DAT_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Bits above the 13-bit width field are random; the block must ignore them.
  function automatic logic [CFG_DAT_W-1:0] rand_width_word();
    logic [CFG_DAT_W-1:0] word;
    word = CFG_DAT_W'($urandom_range(0, 65535));
    case ($urandom_range(0, 19))
      0:       word[WIDTH_W-1:0] = '0;
      1, 2:    word[WIDTH_W-1:0] = WIDTH_W'(1);
      3, 4:    word[WIDTH_W-1:0] = WIDTH_W'(2);
      5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15:
               word[WIDTH_W-1:0] = WIDTH_W'($urandom_range(3, 12));
      default: word[WIDTH_W-1:0] = WIDTH_W'($urandom_range(13, 48));
    endcase
    return word;
  endfunction

  initial begin
    int n;
    int random_sent;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration: unit center tap over 640-sample rows.
    send_pixel('0);
    send_pixel(PIX_MAX);
    send_pixel(16'h8000);
    send_pixel(16'h0001);
    settle();

    // A zero width behaves as one sample per row. Writing the width also abandons the
    // partial row above along with its pending results.
    write_reg(REG_ROW_WIDTH, '0);
    repeat (2) send_pixel(rand_pixel());
    settle();
    write_reg(REG_ROW_WIDTH, 16'd2);
    repeat (3) send_pixel(rand_pixel());
    settle();
    write_reg(REG_ROW_WIDTH, 16'hE003);
    repeat (3) send_pixel(rand_pixel());
    settle();

    // Full-scale taps and samples drive the sum into both saturation limits.
    for (int i = 0; i < NTAPREG; i++) write_reg(REG_TAP_0 + CFG_IDX_W'(i), TAP_MAX);
    write_reg(REG_ROW_WIDTH, 16'd5);
    repeat (5) send_pixel(PIX_MAX);
    settle();
    for (int i = 0; i < NTAPREG; i++) write_reg(REG_TAP_0 + CFG_IDX_W'(i), TAP_MIN);
    repeat (5) send_pixel(PIX_MAX);
    settle();

    // Writes to unused indexes must leave every register alone.
    write_reg(REG_SPARE_LO, CFG_DAT_W'($urandom_range(0, 65535)));
    write_reg(REG_SPARE_HI, CFG_DAT_W'($urandom_range(0, 65535)));
    repeat (3) send_pixel(rand_pixel());

    random_sent = 0;
    while (random_sent < RANDOM_PIXELS) begin
      settle();
      if (random_sent < RANDOM_PIXELS / 3) begin
        send_gap_pct = 18;
        recv_gap_pct = 75;
      end else if (random_sent < 2 * RANDOM_PIXELS / 3) begin
        send_gap_pct = 75;
        recv_gap_pct = 18;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      // Tap-only updates keep the row position, so some rows continue across the write.
      case ($urandom_range(0, 3))
        0: begin
          for (int i = 0; i < NTAPREG; i++) write_reg(REG_TAP_0 + CFG_IDX_W'(i), rand_tap());
        end
        1: begin
          write_reg(REG_ROW_WIDTH, rand_width_word());
        end
        default: begin
          for (int i = 0; i < NTAPREG; i++) write_reg(REG_TAP_0 + CFG_IDX_W'(i), rand_tap());
          write_reg(REG_ROW_WIDTH, rand_width_word());
        end
      endcase
      n = $urandom_range(6, 30);
      repeat (n) send_pixel(rand_pixel());
      random_sent += n;
    end
    settle();

    // A width request above the maximum saturates; the row of WIDE_PIXELS samples runs past
    // every random width under WIDE_PIXELS used above.
    write_reg(REG_ROW_WIDTH, WIDTH_OVER);
    repeat (WIDE_PIXELS) send_pixel(rand_pixel());
    settle();

    if (errors == 0 && outstanding == 0) begin
      $display("fir_row_filter_reflect_border_tb: done, clean");
    end else begin
      $display("fir_row_filter_reflect_border_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("fir_row_filter_reflect_border_tb: done, errors");
    $finish;
  end

endmodule
